/* rtl/core/tpt_pkg.sv */
// Shared types, constants and helpers for the tracker presence table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tpt_pkg;

    localparam int TRACKERS      = 64;
    localparam int HIST_DEPTH    = 8;
    localparam int ENT_AW        = $clog2(TRACKERS);
    localparam int CNT_W         = $clog2(TRACKERS + 1);
    localparam int HPOS_W        = $clog2(HIST_DEPTH);
    localparam int HUSED_W       = $clog2(HIST_DEPTH + 1);
    localparam int HIST_AW       = ENT_AW + HPOS_W;
    localparam int HIST_WORDS    = TRACKERS * HIST_DEPTH;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRACKER_LIMIT   = 3'd4;

    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] now_ms;
        logic [47:0] address;
        logic [7:0]  address_type;
        logic [7:0]  data_length;
        logic [31:0] data_digest;
        logic        tag_format;
    } in_t;

    typedef struct packed {
        logic [5:0] slot;
        logic       matched;
        logic       added;
        logic       dropped;
        logic       storage_full;
        logic       data_updated;
        logic [6:0] lost_count;
    } out_t;

    typedef struct packed {
        logic [31:0] lost_timeout;
        logic [31:0] sample_interval;
        logic [3:0]  history_limit;
        logic [6:0]  notify_count;
        logic [6:0]  tracker_limit;
    } cfg_t;

    // One tracker entry: key, stored payload summary and history ring pointers.
    typedef struct packed {
        logic [47:0]        address;
        logic [7:0]         addr_type;
        logic [7:0]         data_len;
        logic [31:0]        digest;
        logic               tag_flag;
        logic [HPOS_W-1:0]  head;
        logic [HUSED_W-1:0] used;
    } ent_t;

    // One presence history.
    typedef struct packed {
        logic        present;
        logic [31:0] first_seen;
        logic [31:0] last_sample;
        logic [31:0] last_seen;
        logic [31:0] found;
        logic [31:0] lost_time;
    } hist_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_HIT_UPD,
        ST_MISS,
        ST_AGE_RD,
        ST_AGE_RDH,
        ST_AGE_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic ent_rd;
        logic hist_rd;
        logic idx_inc;
        logic hit_update;
        logic miss_update;
        logic age_check;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic aging_off;
        logic table_empty;
        logic match;
        logic last_entry;
        logic out_free;
    } stat_t;

    // Ring position of the newest history; an empty ring points at its head.
    function automatic logic [HPOS_W-1:0] newest_pos(input logic [HPOS_W-1:0] head,
                                                     input logic [HUSED_W-1:0] used);
        logic [HUSED_W-1:0] used_eff;
        used_eff = (used == '0) ? HUSED_W'(1) : used;
        return head + HPOS_W'(used_eff - HUSED_W'(1));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the entry table and the history store.
`default_nettype none

module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tpt_ctrl.sv */
// Sequencer of the tracker presence table: search, update and aging sweeps.
// Depends on tpt_pkg for the state, command and status types.
`default_nettype none

module tpt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire tpt_pkg::stat_t stat,
    output tpt_pkg::cmd_t      cmd
);
    import tpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_tick)
                begin
                    state_next = (stat.aging_off || stat.table_empty) ? ST_DONE : ST_AGE_RD;
                end
                else
                begin
                    state_next = stat.table_empty ? ST_MISS : ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                cmd.ent_rd = 1'b1;
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    cmd.hist_rd = 1'b1;
                    state_next  = ST_HIT_UPD;
                end
                else if (stat.last_entry)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRCH_RD;
                end
            end
            ST_HIT_UPD:
            begin
                cmd.hit_update = 1'b1;
                state_next     = ST_DONE;
            end
            ST_MISS:
            begin
                cmd.miss_update = 1'b1;
                state_next      = ST_DONE;
            end
            ST_AGE_RD:
            begin
                cmd.ent_rd = 1'b1;
                state_next = ST_AGE_RDH;
            end
            ST_AGE_RDH:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_AGE_CHK;
            end
            ST_AGE_CHK:
            begin
                cmd.age_check = 1'b1;
                if (stat.last_entry)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_AGE_RD;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/tpt_datapath.sv */
// Datapath of the tracker presence table: registers, entry and history RAMs,
// update logic and output register. Depends on tpt_pkg and tpt_ram.
`default_nettype none

module tpt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [tpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire tpt_pkg::in_t                  in_data,
    input  wire tpt_pkg::cmd_t                 cmd,
    output tpt_pkg::stat_t                     stat,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output tpt_pkg::out_t                      out_data
);
    import tpt_pkg::*;

    cfg_t              cfg_reg;
    in_t               item_reg;
    ent_t              ent_reg;
    out_t              res_reg;
    out_t              res_next;
    out_t              out_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ENT_AW-1:0] idx_reg;
    logic [CNT_W-1:0]  count_reg;

    ent_t               ent_rdata;
    hist_t              hist_rdata;
    logic               ent_we;
    logic [ENT_AW-1:0]  ent_waddr;
    ent_t               ent_wdata;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr;
    hist_t              hist_wdata;
    logic [HIST_AW-1:0] hist_raddr;

    logic [3:0]         hist_lim;
    logic               need_open;
    logic [HPOS_W-1:0]  pos;
    logic [HPOS_W-1:0]  head1;
    logic [HUSED_W-1:0] used1;
    logic [31:0]        sample_due;
    logic [31:0]        lost_due;
    logic               keep_payload;
    logic               full;
    logic               drop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lost_timeout    <= '0;
            cfg_reg.sample_interval <= '0;
            cfg_reg.history_limit   <= 4'd8;
            cfg_reg.notify_count    <= 7'd64;
            cfg_reg.tracker_limit   <= 7'd64;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LOST_TIMEOUT:    cfg_reg.lost_timeout    <= cfg_data;
                REG_SAMPLE_INTERVAL: cfg_reg.sample_interval <= cfg_data;
                REG_HISTORY_LIMIT:   cfg_reg.history_limit   <= cfg_data[3:0];
                REG_NOTIFY_COUNT:    cfg_reg.notify_count    <= cfg_data[6:0];
                REG_TRACKER_LIMIT:   cfg_reg.tracker_limit   <= cfg_data[6:0];
                default:             ;
            endcase
        end
    end

    tpt_ram #(.WIDTH($bits(ent_t)), .DEPTH(TRACKERS)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (cmd.ent_rd),
        .raddr (idx_reg),
        .rdata (ent_rdata)
    );

    tpt_ram #(.WIDTH($bits(hist_t)), .DEPTH(HIST_WORDS)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (cmd.hist_rd),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign hist_raddr = {idx_reg, newest_pos(ent_rdata.head, ent_rdata.used)};

    // Status toward the controller.
    always_comb
    begin
        stat.is_tick     = (item_reg.func == FUNC_TICK);
        stat.aging_off   = (cfg_reg.lost_timeout == '0);
        stat.table_empty = (count_reg == '0);
        stat.match       = (ent_rdata.address == item_reg.address) &&
                           (ent_rdata.addr_type == item_reg.address_type);
        stat.last_entry  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        stat.out_free    = !out_valid_reg || !out_stall;
    end

    // Update logic for hits, misses and aging.
    always_comb
    begin
        if (cfg_reg.history_limit == 4'd0)
        begin
            hist_lim = 4'd1;
        end
        else if (cfg_reg.history_limit > 4'(HIST_DEPTH))
        begin
            hist_lim = 4'(HIST_DEPTH);
        end
        else
        begin
            hist_lim = cfg_reg.history_limit;
        end

        need_open  = (ent_reg.used == '0) || !hist_rdata.present;
        sample_due = hist_rdata.last_sample + cfg_reg.sample_interval;
        lost_due   = hist_rdata.last_seen + cfg_reg.lost_timeout;
        hist_wdata = hist_rdata;
        head1      = ent_reg.head;
        used1      = ent_reg.used;

        if (need_open)
        begin
            if (ent_reg.used >= HUSED_W'(HIST_DEPTH))
            begin
                pos   = ent_reg.head;
                head1 = ent_reg.head + HPOS_W'(1);
                used1 = HUSED_W'(HIST_DEPTH);
            end
            else
            begin
                pos   = ent_reg.head + HPOS_W'(ent_reg.used);
                used1 = ent_reg.used + HUSED_W'(1);
            end
            hist_wdata.present     = 1'b1;
            hist_wdata.first_seen  = item_reg.now_ms;
            hist_wdata.last_sample = item_reg.now_ms;
            hist_wdata.last_seen   = item_reg.now_ms;
            hist_wdata.found       = 32'd1;
            hist_wdata.lost_time   = '0;
        end
        else
        begin
            pos = newest_pos(ent_reg.head, ent_reg.used);
            if (item_reg.now_ms >= sample_due)
            begin
                hist_wdata.found       = hist_rdata.found + 32'd1;
                hist_wdata.last_sample = item_reg.now_ms;
            end
            hist_wdata.last_seen = item_reg.now_ms;
        end

        keep_payload = (item_reg.data_length == '0) ||
                       ((ent_reg.data_len != '0) &&
                        (((ent_reg.data_len == item_reg.data_length) &&
                          (ent_reg.digest == item_reg.data_digest)) ||
                         (ent_reg.tag_flag && !item_reg.tag_format)));

        full = (count_reg >= cfg_reg.notify_count);
        drop = (full && (count_reg >= cfg_reg.tracker_limit)) ||
               (count_reg >= CNT_W'(TRACKERS));

        ent_we     = 1'b0;
        ent_waddr  = idx_reg;
        ent_wdata  = ent_reg;
        hist_we    = 1'b0;
        hist_waddr = {idx_reg, pos};
        res_next   = res_reg;

        if (cmd.load_item)
        begin
            res_next = '0;
        end

        if (cmd.hit_update)
        begin
            ent_we              = 1'b1;
            hist_we             = 1'b1;
            ent_wdata.address   = item_reg.address;
            ent_wdata.addr_type = item_reg.address_type;
            if (!keep_payload)
            begin
                ent_wdata.data_len = item_reg.data_length;
                ent_wdata.digest   = item_reg.data_digest;
                ent_wdata.tag_flag = item_reg.tag_format;
            end
            // At most one oldest history is trimmed per report, besides one a full ring overwrites.
            if (used1 > HUSED_W'(hist_lim))
            begin
                ent_wdata.head = head1 + HPOS_W'(1);
                ent_wdata.used = used1 - HUSED_W'(1);
            end
            else
            begin
                ent_wdata.head = head1;
                ent_wdata.used = used1;
            end
            res_next.slot         = 6'(idx_reg);
            res_next.matched      = 1'b1;
            res_next.data_updated = !keep_payload;
        end

        if (cmd.miss_update)
        begin
            res_next.storage_full = full;
            if (drop)
            begin
                res_next.dropped = 1'b1;
            end
            else
            begin
                ent_we              = 1'b1;
                ent_waddr           = count_reg[ENT_AW-1:0];
                ent_wdata.address   = item_reg.address;
                ent_wdata.addr_type = item_reg.address_type;
                ent_wdata.data_len  = item_reg.data_length;
                ent_wdata.digest    = (item_reg.data_length != '0) ?
                                      item_reg.data_digest : '0;
                ent_wdata.tag_flag  = (item_reg.data_length != '0) && item_reg.tag_format;
                ent_wdata.head      = '0;
                ent_wdata.used      = HUSED_W'(1);
                hist_we             = 1'b1;
                hist_waddr          = {count_reg[ENT_AW-1:0], HPOS_W'(0)};
                hist_wdata.present     = 1'b1;
                hist_wdata.first_seen  = item_reg.now_ms;
                hist_wdata.last_sample = item_reg.now_ms;
                hist_wdata.last_seen   = item_reg.now_ms;
                hist_wdata.found       = 32'd1;
                hist_wdata.lost_time   = '0;
                res_next.slot          = 6'(count_reg);
                res_next.added         = 1'b1;
                res_next.data_updated  = (item_reg.data_length != '0);
            end
        end

        if (cmd.age_check)
        begin
            hist_waddr = {idx_reg, newest_pos(ent_reg.head, ent_reg.used)};
            hist_wdata = hist_rdata;
            if ((ent_reg.used != '0) && hist_rdata.present && (item_reg.now_ms >= lost_due))
            begin
                hist_we              = 1'b1;
                hist_wdata.present   = 1'b0;
                hist_wdata.lost_time = item_reg.now_ms;
                res_next.lost_count  = res_reg.lost_count + 7'd1;
            end
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.load_item)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + ENT_AW'(1);
            end
            if (cmd.miss_update && !drop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.hist_rd)
        begin
            ent_reg <= ent_rdata;
        end
        res_reg <= res_next;
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/core/tracker_presence_table.sv */
// Top level of the tracker presence table.
// Depends on tpt_pkg, tpt_ctrl, tpt_datapath and, through it, tpt_ram.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one item per
// transfer, either an advertising report or an aging tick. The output channel
// (out_valid, out_stall, out_data) returns exactly one result per item, in order.
// Registers are written through cfg_write, cfg_index and cfg_data while the block
// is idle; indexes beyond the last register are ignored.
// The block works on one item at a time. A report walks the table entry by entry,
// each entry with a registered RAM read and then a compare, and stops at a match
// or after the last stored entry. A tick visits every stored tracker in turn with
// an entry read, a history read, and a check and write back; with aging off or an
// empty table it visits none.
// The output register decouples the two sides: a new item is taken while the
// previous result still waits. When the receiver stalls, the finished result of
// the next item waits inside until the output register is free.
// Reset empties the table at once through the tracker count, so no clearing pass
// is needed, and loads the register defaults.
`default_nettype none

module tracker_presence_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [tpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire tpt_pkg::in_t                  in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output tpt_pkg::out_t                      out_data
);
    import tpt_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    cmd_t  cmd;
    stat_t stat;

    tpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* sim/tracker_presence_table_tb.sv */
// Self-checking testbench for the tracker presence table.
// Depends on tpt_pkg and tracker_presence_table; holds its own table predictor.
`default_nettype none

module tracker_presence_table_tb;
    import tpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 6000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;

    tracker_presence_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the register file.
    logic [31:0] lost_timeout_q;
    logic [31:0] sample_interval_q;
    logic [3:0]  history_limit_q;
    logic [6:0]  notify_count_q;
    logic [6:0]  tracker_limit_q;

    // Shadow copy of the table. Every field starts at zero here; the block may
    // hold anything in the history words, but only written ones are ever read.
    logic        tbl_valid     [TRACKERS];
    logic [47:0] tbl_address   [TRACKERS];
    logic [7:0]  tbl_addr_type [TRACKERS];
    logic [7:0]  tbl_data_len  [TRACKERS];
    logic [31:0] tbl_digest    [TRACKERS];
    logic        tbl_tag_flag  [TRACKERS];
    logic [2:0]  ring_head     [TRACKERS];
    logic [3:0]  ring_used     [TRACKERS];
    logic [6:0]  tbl_count;
    logic        seen_present  [TRACKERS][HIST_DEPTH];
    logic [31:0] seen_first    [TRACKERS][HIST_DEPTH];
    logic [31:0] seen_sample   [TRACKERS][HIST_DEPTH];
    logic [31:0] seen_last     [TRACKERS][HIST_DEPTH];
    logic [31:0] seen_found    [TRACKERS][HIST_DEPTH];
    logic [31:0] seen_lost     [TRACKERS][HIST_DEPTH];

    in_t  pending_items[$];
    out_t expected_results[$];

    int   error_count;
    int   reports_sent;
    int   ticks_sent;
    int   hits_seen;
    int   adds_seen;
    int   drops_seen;
    int   full_seen;
    int   lost_seen;
    int   idle_cycles;
    logic stimulus_done;

    // Newest history of a tracker; an empty ring points at its head.
    function automatic logic [2:0] newest_slot(input int e);
        logic [3:0] used_eff;
        used_eff = (ring_used[e] == 4'd0) ? 4'd1 : ring_used[e];
        return ring_head[e] + 3'(used_eff - 4'd1);
    endfunction

    function automatic void open_presence(input int e, input logic [31:0] now);
        logic [2:0] pos;
        if (ring_used[e] >= 4'(HIST_DEPTH))
        begin
            pos          = ring_head[e];
            ring_head[e] = ring_head[e] + 3'd1;
            ring_used[e] = 4'(HIST_DEPTH);
        end
        else
        begin
            pos          = ring_head[e] + ring_used[e][2:0];
            ring_used[e] = ring_used[e] + 4'd1;
        end
        seen_present[e][pos] = 1'b1;
        seen_first[e][pos]   = now;
        seen_sample[e][pos]  = now;
        seen_last[e][pos]    = now;
        seen_found[e][pos]   = 32'd1;
        seen_lost[e][pos]    = 32'd0;
    endfunction

    // Stores the key and decides whether the payload summary is replaced.
    function automatic logic merge_payload(input int e, input in_t it);
        tbl_address[e]   = it.address;
        tbl_addr_type[e] = it.address_type;
        if (it.data_length == 8'd0)
            return 1'b0;
        // A tag-format payload is kept over other formats, and an identical
        // payload is not rewritten.
        if (tbl_data_len[e] != 8'd0 &&
            ((tbl_data_len[e] == it.data_length && tbl_digest[e] == it.data_digest) ||
             (tbl_tag_flag[e] && !it.tag_format)))
            return 1'b0;
        tbl_data_len[e] = it.data_length;
        tbl_digest[e]   = it.data_digest;
        tbl_tag_flag[e] = it.tag_format;
        return 1'b1;
    endfunction

    function automatic out_t track_item(input in_t it);
        out_t       res;
        logic [2:0] pos;
        logic [3:0] lim;
        int         e;
        int         lost;
        logic       hit;
        logic       drop;
        res  = '0;
        lost = 0;
        if (it.func == FUNC_TICK)
        begin
            if (lost_timeout_q != 32'd0)
            begin
                for (e = 0; e < TRACKERS; e++)
                begin
                    if (tbl_valid[e] && ring_used[e] != 4'd0)
                    begin
                        pos = newest_slot(e);
                        if (seen_present[e][pos] &&
                            it.now_ms >= 32'(seen_last[e][pos] + lost_timeout_q))
                        begin
                            seen_present[e][pos] = 1'b0;
                            seen_lost[e][pos]    = it.now_ms;
                            lost++;
                        end
                    end
                end
            end
            res.lost_count = 7'(lost);
            return res;
        end

        hit = 1'b0;
        for (e = 0; e < TRACKERS && !hit; e++)
        begin
            if (tbl_valid[e] && tbl_addr_type[e] == it.address_type &&
                tbl_address[e] == it.address)
            begin
                hit = 1'b1;
                res.slot = 6'(e);
            end
        end

        if (hit)
        begin
            e   = int'(res.slot);
            lim = history_limit_q;
            if (lim == 4'd0)
                lim = 4'd1;
            if (lim > 4'(HIST_DEPTH))
                lim = 4'(HIST_DEPTH);
            res.matched = 1'b1;
            pos = newest_slot(e);
            if (ring_used[e] == 4'd0 || !seen_present[e][pos])
                open_presence(e, it.now_ms);
            else
            begin
                // Sightings are counted at most once per sample interval.
                if (it.now_ms >= 32'(seen_sample[e][pos] + sample_interval_q))
                begin
                    seen_found[e][pos]  = seen_found[e][pos] + 32'd1;
                    seen_sample[e][pos] = it.now_ms;
                end
                seen_last[e][pos] = it.now_ms;
            end
            res.data_updated = merge_payload(e, it);
            // Only the single oldest history is trimmed per report, besides one a full ring overwrites.
            if (ring_used[e] > lim)
            begin
                ring_head[e] = ring_head[e] + 3'd1;
                ring_used[e] = ring_used[e] - 4'd1;
            end
        end
        else
        begin
            drop = 1'b0;
            // The tracker limit only counts once the notify threshold is met.
            if (tbl_count >= notify_count_q)
            begin
                res.storage_full = 1'b1;
                if (tbl_count >= tracker_limit_q)
                    drop = 1'b1;
            end
            if (tbl_count >= 7'(TRACKERS))
                drop = 1'b1;
            if (drop)
                res.dropped = 1'b1;
            else
            begin
                e                = int'(tbl_count);
                tbl_valid[e]     = 1'b1;
                tbl_data_len[e]  = 8'd0;
                tbl_digest[e]    = 32'd0;
                tbl_tag_flag[e]  = 1'b0;
                ring_head[e]     = 3'd0;
                ring_used[e]     = 4'd0;
                res.data_updated = merge_payload(e, it);
                open_presence(e, it.now_ms);
                tbl_count        = tbl_count + 7'd1;
                res.slot         = 6'(e);
                res.added        = 1'b1;
            end
        end
        return res;
    endfunction

    // Sender: bursts of random length with random gaps. A payload only moves
    // on to the next item once the current transfer has happened.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.insert(expected_results.size(), track_item(in_data));
                if (in_data.func == FUNC_TICK)
                    ticks_sent++;
                else
                    reports_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        // Some stretches run back to back with no gap at all.
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern switches at random between free flow, light, heavy
    // and periodic stalling.
    int stall_mode;
    int stall_span;
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_mode  <= 0;
            stall_span  <= 0;
            stall_phase <= 0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_span <= $urandom_range(20, 120);
            end
            else
                stall_span <= stall_span - 1;
            stall_phase <= stall_phase + 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 30);
                2:       out_stall <= ($urandom_range(0, 99) < 80);
                default: out_stall <= (stall_phase % 7 < 3);
            endcase
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no expectation waiting: %p", out_data);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
                    error_count++;
                end
                if (out_data.matched !== want.matched)
                begin
                    $error("matched: expected %0b, got %0b", want.matched, out_data.matched);
                    error_count++;
                end
                if (out_data.added !== want.added)
                begin
                    $error("added: expected %0b, got %0b", want.added, out_data.added);
                    error_count++;
                end
                if (out_data.dropped !== want.dropped)
                begin
                    $error("dropped: expected %0b, got %0b", want.dropped, out_data.dropped);
                    error_count++;
                end
                if (out_data.storage_full !== want.storage_full)
                begin
                    $error("storage_full: expected %0b, got %0b",
                           want.storage_full, out_data.storage_full);
                    error_count++;
                end
                if (out_data.data_updated !== want.data_updated)
                begin
                    $error("data_updated: expected %0b, got %0b",
                           want.data_updated, out_data.data_updated);
                    error_count++;
                end
                if (out_data.lost_count !== want.lost_count)
                begin
                    $error("lost_count: expected %0d, got %0d",
                           want.lost_count, out_data.lost_count);
                    error_count++;
                end
                hits_seen  += want.matched;
                adds_seen  += want.added;
                drops_seen += want.dropped;
                full_seen  += want.storage_full;
                lost_seen  += want.lost_count;
            end
        end
    end

    // Watchdog: a run with no transfer on either side for too long is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (pending_items.size() == 0 && expected_results.size() == 0 && !in_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("tracker_presence_table_tb NOT OK");
            $finish;
        end
    end

    // Stimulus generation state.
    logic [31:0] clock_ms;
    logic [47:0] known_addr[$];
    logic [7:0]  known_type[$];

    // Appends one item to the end of the sender's queue.
    task automatic queue_item(input in_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_LOST_TIMEOUT:    lost_timeout_q    = value;
            REG_SAMPLE_INTERVAL: sample_interval_q = value;
            REG_HISTORY_LIMIT:   history_limit_q   = value[3:0];
            REG_NOTIFY_COUNT:    notify_count_q    = value[6:0];
            REG_TRACKER_LIMIT:   tracker_limit_q   = value[6:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] lost_to, input logic [31:0] sample,
                            input logic [31:0] hist, input logic [31:0] notify,
                            input logic [31:0] limit);
        wait_idle();
        write_reg(REG_LOST_TIMEOUT, lost_to);
        write_reg(REG_SAMPLE_INTERVAL, sample);
        write_reg(REG_HISTORY_LIMIT, hist);
        write_reg(REG_NOTIFY_COUNT, notify);
        write_reg(REG_TRACKER_LIMIT, limit);
    endtask

    function automatic in_t make_report(input logic [31:0] now, input logic [47:0] addr,
                                        input logic [7:0] atype, input logic [7:0] len,
                                        input logic [31:0] dig, input logic tag);
        in_t it;
        it              = '0;
        it.func         = FUNC_REPORT;
        it.now_ms       = now;
        it.address      = addr;
        it.address_type = atype;
        it.data_length  = len;
        it.data_digest  = dig;
        it.tag_format   = tag;
        return it;
    endfunction

    // Random phase: mostly reports from a pool of known trackers so that
    // histories, sampling and payload merging get exercised, plus new
    // addresses and aging ticks. Time mostly creeps forward with jumps.
    task automatic random_phase(input int count, input int tick_pct, input int new_pct);
        in_t     it;
        int      k;
        int      pick;
        logic [7:0]  len;
        logic [31:0] dig;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 19))
                0:       clock_ms = clock_ms + $urandom;
                1:       clock_ms = clock_ms + $urandom_range(200, 5000);
                default: clock_ms = clock_ms + $urandom_range(0, 40);
            endcase
            if ($urandom_range(0, 99) < tick_pct)
            begin
                it        = in_t'({$urandom, $urandom, $urandom, $urandom});
                it.func   = FUNC_TICK;
                it.now_ms = clock_ms;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:    len = 8'd0;
                    2:       len = 8'($urandom_range(1, 255));
                    3:       len = 8'd31;
                    default: len = 8'd255;
                endcase
                dig = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 2)) * 32'h5A5A_0F0F
                                                  : 32'($urandom);
                if (known_addr.size() == 0 || $urandom_range(0, 99) < new_pct)
                begin
                    known_addr.insert(known_addr.size(), {16'($urandom), 32'($urandom)});
                    known_type.insert(known_type.size(),
                                      ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                                                  : 8'($urandom));
                    k = known_addr.size() - 1;
                end
                else
                begin
                    // Favor recent addresses so hits land on stored trackers.
                    pick = $urandom_range(0, (known_addr.size() > 40) ? 39 : known_addr.size() - 1);
                    k    = known_addr.size() - 1 - pick;
                end
                it = make_report(clock_ms, known_addr[k], known_type[k], len, dig,
                                 $urandom_range(0, 2) == 0);
                // Same address with another type is a different tracker.
                if ($urandom_range(0, 29) == 0)
                    it.address_type = it.address_type ^ 8'h80;
            end
            queue_item(it);
        end
    endtask

    initial
    begin
        in_t it;
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        lost_timeout_q    = 32'd0;
        sample_interval_q = 32'd0;
        history_limit_q   = 4'd8;
        notify_count_q    = 7'd64;
        tracker_limit_q   = 7'd64;
        tbl_count         = 7'd0;
        error_count       = 0;
        reports_sent      = 0;
        ticks_sent        = 0;
        hits_seen         = 0;
        adds_seen         = 0;
        drops_seen        = 0;
        full_seen         = 0;
        lost_seen         = 0;
        idle_cycles       = 0;
        stimulus_done     = 1'b0;
        clock_ms          = 32'd1000;
        for (int e = 0; e < TRACKERS; e++)
        begin
            tbl_valid[e]     = 1'b0;
            tbl_address[e]   = '0;
            tbl_addr_type[e] = '0;
            tbl_data_len[e]  = '0;
            tbl_digest[e]    = '0;
            tbl_tag_flag[e]  = 1'b0;
            ring_head[e]     = '0;
            ring_used[e]     = '0;
            for (int h = 0; h < HIST_DEPTH; h++)
            begin
                seen_present[e][h] = 1'b0;
                seen_first[e][h]   = '0;
                seen_sample[e][h]  = '0;
                seen_last[e][h]    = '0;
                seen_found[e][h]   = '0;
                seen_lost[e][h]    = '0;
            end
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset defaults: aging is off, so a tick loses
        // nothing. Extremes of the key, payload replacement rules and the
        // empty payload case.
        it        = '0;
        it.func   = FUNC_TICK;
        it.now_ms = 32'hFFFF_FFFF;
        queue_item(it);
        queue_item(make_report(32'd0, 48'd0, 8'd0, 8'd0, 32'd0, 1'b0));
        queue_item(make_report(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF,
                               8'hFF, 32'hFFFF_FFFF, 1'b1));
        queue_item(make_report(32'd5, 48'd0, 8'd0, 8'd10, 32'h1234, 1'b0));
        // Same length and digest: kept.
        queue_item(make_report(32'd6, 48'd0, 8'd0, 8'd10, 32'h1234, 1'b1));
        // Tag format replaces a plain payload, then a plain one cannot replace it.
        queue_item(make_report(32'd7, 48'd0, 8'd0, 8'd12, 32'h1234, 1'b1));
        queue_item(make_report(32'd8, 48'd0, 8'd0, 8'd20, 32'h9999, 1'b0));
        queue_item(make_report(32'd9, 48'd0, 8'd0, 8'd0, 32'h7777, 1'b1));
        queue_item(make_report(32'd10, 48'd0, 8'd1, 8'd1, 32'h0, 1'b0));
        queue_item(make_report(32'd11, 48'hFFFF_FFFF_FFFF, 8'hFF,
                               8'd1, 32'd0, 1'b0));
        queue_item(make_report(32'd12, 48'h8000_0000_0001, 8'h80,
                               8'd0, 32'd0, 1'b0));
        random_phase(120, 10, 15);

        // Tracker limit below the notify threshold, one history per tracker,
        // short lost timeout so ticks turn trackers absent.
        set_regs(32'd60, 32'd0, 32'd1, 32'd10, 32'd5);
        wait_idle();
        it        = '0;
        it.func   = FUNC_TICK;
        it.now_ms = clock_ms + 32'd1000;
        queue_item(it);
        random_phase(300, 20, 20);

        // History limit of zero, a sample interval, and a wide gap between
        // the notify threshold and the tracker limit.
        set_regs(32'd150, 32'd25, 32'd0, 32'd20, 32'd30);
        random_phase(300, 15, 15);

        // Out of range history limit with junk in the upper data bits, largest
        // intervals, and time wrapping past zero.
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd64, 32'd64);
        clock_ms = 32'hFFFF_FF00;
        random_phase(300, 10, 12);

        // Three histories, moderate aging, notify and limit at zero.
        set_regs(32'd80, 32'd5, 32'hABCD_0013, 32'd0, 32'd0);
        random_phase(300, 20, 10);

        // Aging off, thresholds beyond the table so only a full table drops.
        set_regs(32'd0, 32'd1, 32'd8, 32'd127, 32'd127);
        random_phase(250, 15, 15);
        set_regs(32'd1, 32'd0, 32'd2, 32'd64, 32'd127);
        random_phase(250, 25, 10);

        wait (pending_items.size() == 0 && !in_valid);
        stimulus_done = 1'b1;
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);

        $display("covered %0d reports and %0d ticks: %0d hits, %0d adds, %0d drops",
                 reports_sent, ticks_sent, hits_seen, adds_seen, drops_seen);
        $display("%0d full events and %0d trackers turned absent, %0d errors",
                 full_seen, lost_seen, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tracker_presence_table_tb OK");
        else
            $display("tracker_presence_table_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
